// File: src/rpss_pkg.sv
package rpss_pkg;

  localparam int unsigned SampleW = 16;
  localparam int unsigned CfgIdxW = 4;

  // Register indexes on the configuration port
  localparam logic [CfgIdxW-1:0] CfgMinVoltLowRail  = 4'd0;
  localparam logic [CfgIdxW-1:0] CfgMaxVoltLowRail  = 4'd1;
  localparam logic [CfgIdxW-1:0] CfgMinVoltHighRail = 4'd2;
  localparam logic [CfgIdxW-1:0] CfgMaxVoltHighRail = 4'd3;

  localparam logic signed [SampleW-1:0] MinVoltReset = 16'sd0;
  localparam logic signed [SampleW-1:0] MaxVoltReset = 16'sd32767;

  typedef enum logic [1:0] {
    RailNone    = 2'd0,
    RailBothOff = 2'd1,
    RailLowOn   = 2'd2,
    RailBothOn  = 2'd3
  } rail_act_e;

  typedef enum logic [1:0] {
    FanNone    = 2'd0,
    FanFullOff = 2'd1,
    FanFullOn  = 2'd2
  } fan_act_e;

  typedef enum logic [1:0] {
    ToneNone     = 2'd0,
    ToneBadPower = 2'd1,
    ToneEstopOn  = 2'd2,
    ToneEstopOff = 2'd3
  } tone_e;

  // State bits: [0] 16 V on, [1] on/off pressed, [2] kill closed, [3] 32 V on
  typedef logic [3:0] flags_t;

  typedef struct packed {
    logic signed [SampleW-1:0] min_low;
    logic signed [SampleW-1:0] max_low;
    logic signed [SampleW-1:0] min_high;
    logic signed [SampleW-1:0] max_high;
  } limits_t;

  typedef struct packed {
    logic                      kill_level;
    logic                      onoff_level;
    logic signed [SampleW-1:0] low_a;
    logic signed [SampleW-1:0] low_b;
    logic signed [SampleW-1:0] low_c;
    logic signed [SampleW-1:0] high_a;
    logic signed [SampleW-1:0] high_b;
    logic signed [SampleW-1:0] high_c;
  } event_t;

  typedef struct packed {
    rail_act_e rail_action;
    fan_act_e  fan_action;
    tone_e     tone_request;
    logic      low_rail_on;
    logic      high_rail_on;
  } result_t;

endpackage

// File: src/rpss_decide.sv
module rpss_decide import rpss_pkg::*; (
  input  event_t  evt_i,
  input  flags_t  flags_i,
  input  limits_t limits_i,
  output flags_t  flags_o,
  output result_t result_o
);

  logic [1:0] sw_now;
  logic [1:0] sw_prev;
  logic signed [SampleW-1:0] low_ab;
  logic signed [SampleW-1:0] low_max;
  logic signed [SampleW-1:0] high_ab;
  logic signed [SampleW-1:0] high_max;
  logic low_ok;
  logic high_ok;
  flags_t cur;

  assign sw_now  = {evt_i.kill_level, ~evt_i.onoff_level};
  assign sw_prev = flags_i[2:1];

  assign low_ab   = (evt_i.low_b > evt_i.low_a) ? evt_i.low_b : evt_i.low_a;
  assign low_max  = (evt_i.low_c > low_ab) ? evt_i.low_c : low_ab;
  assign high_ab  = (evt_i.high_b > evt_i.high_a) ? evt_i.high_b : evt_i.high_a;
  assign high_max = (evt_i.high_c > high_ab) ? evt_i.high_c : high_ab;

  assign low_ok  = (low_max >= limits_i.min_low) && (low_max <= limits_i.max_low);
  assign high_ok = (high_max >= limits_i.min_high) && (high_max <= limits_i.max_high);

  always_comb begin
    cur                   = {flags_i[3], sw_now, flags_i[0]};
    result_o.rail_action  = RailNone;
    result_o.fan_action   = FanNone;
    result_o.tone_request = ToneNone;

    if (flags_i[0]) begin
      // kill held, on/off released after being pressed
      if (sw_now == 2'b10 && sw_prev == 2'b11) begin
        result_o.rail_action = RailBothOff;
        result_o.fan_action  = FanFullOff;
        cur[0] = 1'b0;
        cur[3] = 1'b0;
      end
    end else if (sw_now == 2'b11 && sw_prev == 2'b10) begin
      if (low_ok) begin
        result_o.rail_action = RailLowOn;
        result_o.fan_action  = FanFullOn;
        cur[0] = 1'b1;
        if (high_ok) begin
          result_o.rail_action = RailBothOn;
          cur[3] = 1'b1;
        end
      end else begin
        result_o.tone_request = ToneBadPower;
      end
    end

    if (cur[2] && !flags_i[2]) begin
      result_o.tone_request = ToneEstopOn;
    end else if (!cur[2] && flags_i[2]) begin
      result_o.tone_request = ToneEstopOff;
    end

    result_o.low_rail_on  = cur[0];
    result_o.high_rail_on = cur[3];
    flags_o = cur;
  end

endmodule

// File: src/rail_power_switch_sequencer.sv
// Rail power switch sequencer. Each request is one switch-change event; it is
// captured in an input register, decided against the 4-bit switch/rail state
// and the four range limits in one combinational step, and lands in a result
// register, giving exactly one result per request. The result is valid once
// the request has passed the input register and then the result register;
// a new request is taken every cycle as long as the result register drains,
// and the state update is the loop that sets that rate. Limits are written
// through the configuration port (index 0..3: 16 V min, 16 V max, 32 V min,
// 32 V max, signed Q6.10, inclusive range) and must only change while no
// request is in flight. Other indexes are ignored. Reset clears the state to
// all rails off, switches released.
module rail_power_switch_sequencer import rpss_pkg::*; (
  input  logic                      clk_i,
  input  logic                      rst_ni,

  input  logic                      cfg_valid_i,
  output logic                      cfg_ready_o,
  input  logic [CfgIdxW-1:0]        cfg_index_i,
  input  logic [SampleW-1:0]        cfg_data_i,

  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  logic                      kill_level_i,
  input  logic                      onoff_level_i,
  input  logic signed [SampleW-1:0] low_rail_sample_a_i,
  input  logic signed [SampleW-1:0] low_rail_sample_b_i,
  input  logic signed [SampleW-1:0] low_rail_sample_c_i,
  input  logic signed [SampleW-1:0] high_rail_sample_a_i,
  input  logic signed [SampleW-1:0] high_rail_sample_b_i,
  input  logic signed [SampleW-1:0] high_rail_sample_c_i,

  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output logic [1:0]                rail_action_o,
  output logic [1:0]                fan_action_o,
  output logic [1:0]                tone_request_o,
  output logic                      low_rail_on_o,
  output logic                      high_rail_on_o
);

  limits_t limits_q;
  flags_t  flags_q, flags_d;
  event_t  evt_q;
  logic    evt_valid_q;
  result_t res_q, res_d;
  logic    out_valid_q;
  logic    evt_advance;
  logic    in_fire;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limits_q <= '{min_low: MinVoltReset, max_low: MaxVoltReset,
                    min_high: MinVoltReset, max_high: MaxVoltReset};
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CfgMinVoltLowRail:  limits_q.min_low  <= cfg_data_i;
        CfgMaxVoltLowRail:  limits_q.max_low  <= cfg_data_i;
        CfgMinVoltHighRail: limits_q.min_high <= cfg_data_i;
        CfgMaxVoltHighRail: limits_q.max_high <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Input stage moves on whenever the result register is empty or draining
  assign evt_advance = evt_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o  = !evt_valid_q || evt_advance;
  assign in_fire     = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      evt_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      evt_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      evt_q <= '{kill_level: kill_level_i, onoff_level: onoff_level_i,
                 low_a: low_rail_sample_a_i, low_b: low_rail_sample_b_i,
                 low_c: low_rail_sample_c_i, high_a: high_rail_sample_a_i,
                 high_b: high_rail_sample_b_i, high_c: high_rail_sample_c_i};
    end
  end

  rpss_decide u_decide (
    .evt_i    (evt_q),
    .flags_i  (flags_q),
    .limits_i (limits_q),
    .flags_o  (flags_d),
    .result_o (res_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      flags_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (evt_advance) begin
        flags_q <= flags_d;
      end
      if (!out_valid_q || out_ready_i) begin
        out_valid_q <= evt_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (evt_advance) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign rail_action_o  = res_q.rail_action;
  assign fan_action_o   = res_q.fan_action;
  assign tone_request_o = res_q.tone_request;
  assign low_rail_on_o  = res_q.low_rail_on;
  assign high_rail_on_o = res_q.high_rail_on;

`ifndef ASSERT_OFF
  // 32 V rail is only ever on together with the 16 V rail
  a_high_needs_low: assert property (@(posedge clk_i) disable iff (!rst_ni)
    flags_q[3] |-> flags_q[0])
    else $error("32 V rail flag set without 16 V rail flag");

  a_result_loaded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    evt_advance |=> out_valid_o)
    else $error("decided request did not reach the result register");

  a_bad_power_no_rail: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && tone_request_o == ToneBadPower |-> rail_action_o == RailNone)
    else $error("bad power tone together with a rail action");

  a_both_on_flags: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && rail_action_o == RailBothOn |-> low_rail_on_o && high_rail_on_o)
    else $error("both rails on reported without both flags");
`endif

endmodule
